// ----- rtl/core/skht_pkg.sv -----
`default_nettype none
package skht_pkg;

  localparam int TableDepth = 1024;
  localparam int SlotW = 10;
  localparam int SizeW = 11;
  localparam int KeyChars = 8;
  localparam int KeyW = 64;
  localparam int ValW = 32;

  localparam logic [1:0] StStored = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StHit = 2'd2;
  localparam logic [1:0] StMiss = 2'd3;

  localparam logic OpStore = 1'b0;
  localparam logic OpFetch = 1'b1;

  typedef struct packed {
    logic op;
    logic [KeyW-1:0] key;
    logic [3:0] key_length;
    logic [ValW-1:0] value;
  } skht_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [SlotW-1:0] slot;
    logic [ValW-1:0] found_value;
  } skht_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_HASH, S_POLY, S_MOD1, S_SUM, S_MOD2,
    S_READ, S_WAIT, S_CHECK, S_DONE
  } skht_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item, init hash
    logic hash_step;  // one character
    logic mod_start;  // start remainder unit
    logic sel_sum;    // remainder operand: 0 poly, 1 combined sum
    logic take_h1;    // latch h1 from remainder
    logic take_home;  // latch home from remainder (with sign fix)
    logic rd;         // read slot at probe index
    logic wr;         // write slot at probe index
    logic advance;    // next probe
    logic clr_step;   // clear sweep step
    logic clr_init;   // start clear sweep
    logic emit;       // drive result
    logic [1:0] res_status;
  } skht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic mod_done;
    logic clr_done;
    logic used;
    logic key_eq;
    logic last_probe;
    logic op;
  } skht_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/skht_rem.sv -----
`default_nettype none
// signed 32 by unsigned 11-bit truncating remainder, one bit per cycle
module skht_rem
  import skht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       dividend,
  input  wire logic [SizeW-1:0]  divisor,
  output logic                   done,
  output logic signed [SizeW:0]  rem
);
  logic [31:0] mag;
  logic [SizeW:0] acc;
  logic [5:0] cnt;
  logic neg;
  logic busy;
  logic [SizeW+1:0] trial;

  assign trial = {acc, mag[31]} - {2'b00, divisor};

  // shift-subtract over 32 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        neg <= dividend[31];
        mag <= dividend[31] ? (~dividend + 32'd1) : dividend;
        acc <= '0;
      end else if (busy) begin
        mag <= {mag[30:0], 1'b0};
        if (!trial[SizeW+1]) acc <= trial[SizeW:0];
        else acc <= {acc[SizeW-1:0], mag[31]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = neg ? -$signed(acc) : $signed(acc);
endmodule
`default_nettype wire

// ----- rtl/core/skht_datapath.sv -----
`default_nettype none
// hashing, remainder unit, probe index and slot memory
module skht_datapath
  import skht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [SizeW-1:0] cfg_data,
  input  wire skht_in_t         item,
  input  wire skht_cmd_t        cmd,
  output skht_sts_t             sts,
  output skht_out_t             res,
  output logic                  res_valid
);
  logic [SizeW-1:0] n;
  logic [KeyW-1:0] ck;
  logic [ValW-1:0] val;
  logic op;
  logic [3:0] len;
  logic [3:0] ci;
  logic ended;
  logic [31:0] p, d;
  logic signed [SizeW:0] h1;
  logic [SlotW-1:0] idx;
  logic [SizeW-1:0] probes;
  logic [SlotW-1:0] clr_idx;
  logic clr_last;

  logic used_mem [TableDepth];
  logic [KeyW-1:0] key_mem [TableDepth];
  logic [ValW-1:0] val_mem [TableDepth];
  logic used_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;

  logic rem_done;
  logic signed [SizeW:0] rem;
  logic [31:0] sum;
  logic [7:0] ch;
  logic [SizeW-1:0] cfg_n;

  // clamp written size
  always_comb begin
    if (cfg_data == '0) cfg_n = SizeW'(1);
    else if (cfg_data > SizeW'(TableDepth)) cfg_n = SizeW'(TableDepth);
    else cfg_n = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) n <= SizeW'(TableDepth);
    else if (cfg_we) n <= cfg_n;
  end

  assign ch = ck[KeyW-1-8*ci[2:0] -: 8];
  assign sum = 32'($signed(h1)) + 32'(n) * d;

  skht_rem u_rem (
    .clk(clk), .rst(rst), .start(cmd.mod_start),
    .dividend(cmd.sel_sum ? sum : p), .divisor(n),
    .done(rem_done), .rem(rem)
  );

  // item capture, hash one character per cycle with canonical key
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= item.op;
      val <= item.value;
      ck <= item.key;
      len <= (item.key_length > 4'(KeyChars)) ? 4'(KeyChars) : item.key_length;
      ci <= '0;
      ended <= 1'b0;
      p <= '0;
      d <= 32'd5381;
    end else if (cmd.hash_step) begin
      if (ended || ci >= len || ch == 8'd0) begin
        ended <= 1'b1;
        ck[KeyW-1-8*ci[2:0] -: 8] <= 8'd0;
      end else begin
        p <= 32'd31 * p + 32'(ch);
        d <= (d << 5) + d + 32'(ch);
      end
      ci <= ci + 4'd1;
    end
    if (cmd.take_h1) h1 <= rem;
    if (cmd.take_home) begin
      idx <= SlotW'(rem[SizeW] ? rem + $signed({1'b0, n}) : rem);
      probes <= '0;
    end else if (cmd.advance) begin
      idx <= (SizeW'(idx) + SizeW'(1) == n) ? '0 : idx + SlotW'(1);
      probes <= probes + SizeW'(1);
    end
  end

  // used flags memory with clearing sweep
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) clr_idx <= '0;
    else if (cmd.clr_step) clr_idx <= clr_idx + SlotW'(1);
    if (rst) clr_last <= 1'b0;
    else clr_last <= cmd.clr_step && (clr_idx == SlotW'(TableDepth - 1));
    if (cmd.clr_step) used_mem[clr_idx] <= 1'b0;
    else if (cmd.wr) used_mem[idx] <= 1'b1;
    if (cmd.rd) used_q <= used_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      key_mem[idx] <= ck;
      val_mem[idx] <= val;
    end
    if (cmd.rd) begin
      key_q <= key_mem[idx];
      val_q <= val_mem[idx];
    end
  end

  assign sts.hash_done = (ci == 4'(KeyChars - 1));
  assign sts.mod_done = rem_done;
  assign sts.clr_done = clr_last;
  assign sts.used = used_q;
  assign sts.key_eq = (key_q == ck);
  assign sts.last_probe = (probes + SizeW'(1) == n);
  assign sts.op = op;

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= cmd.emit;
    if (cmd.emit) begin
      res.status <= cmd.res_status;
      res.slot <= (cmd.res_status == StStored || cmd.res_status == StHit) ? idx : '0;
      res.found_value <= (cmd.res_status == StHit) ? val_q : '0;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/skht_ctrl.sv -----
`default_nettype none
// sequencer: clear sweep, hash, two remainders, probe loop
module skht_ctrl
  import skht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      cfg_we,
  input  wire skht_sts_t sts,
  output skht_cmd_t      cmd,
  output logic           busy
);
  skht_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cfg_we) state_next = S_CLEAR; else if (start) state_next = S_HASH;
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_HASH:  if (sts.hash_done) state_next = S_POLY;
      S_POLY:  state_next = S_MOD1;
      S_MOD1:  if (sts.mod_done) state_next = S_SUM;
      S_SUM:   state_next = S_MOD2;
      S_MOD2:  if (sts.mod_done) state_next = S_READ;
      S_READ:  state_next = S_WAIT;
      S_WAIT:  state_next = S_CHECK;
      S_CHECK: begin
        if (sts.op == OpStore) begin
          if (!sts.used || sts.last_probe) state_next = S_DONE;
          else state_next = S_READ;
        end else begin
          if (!sts.used || sts.key_eq || sts.last_probe) state_next = S_DONE;
          else state_next = S_READ;
        end
      end
      S_DONE:  state_next = cfg_we ? S_CLEAR : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE) || cfg_we;
    unique case (state)
      S_IDLE: begin
        cmd.clr_init = cfg_we;
        cmd.load = start && !cfg_we;
      end
      S_CLEAR: cmd.clr_step = !sts.clr_done;
      S_HASH: cmd.hash_step = 1'b1;
      // polynomial hash is final here
      S_POLY: cmd.mod_start = 1'b1;
      S_MOD1: cmd.take_h1 = sts.mod_done;
      S_SUM: begin
        cmd.mod_start = 1'b1;
        cmd.sel_sum = 1'b1;
      end
      S_MOD2: cmd.take_home = sts.mod_done;
      S_READ: cmd.rd = 1'b1;
      S_WAIT: ;
      S_CHECK: begin
        if (sts.op == OpStore) begin
          if (!sts.used) begin
            cmd.wr = 1'b1;
            cmd.emit = 1'b1;
            cmd.res_status = StStored;
          end else if (sts.last_probe) begin
            cmd.emit = 1'b1;
            cmd.res_status = StFull;
          end else cmd.advance = 1'b1;
        end else begin
          if (sts.used && sts.key_eq) begin
            cmd.emit = 1'b1;
            cmd.res_status = StHit;
          end else if (!sts.used || sts.last_probe) begin
            cmd.emit = 1'b1;
            cmd.res_status = StMiss;
          end else cmd.advance = 1'b1;
        end
      end
      S_DONE: cmd.clr_init = cfg_we;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/string_key_hash_table.sv -----
// sequence: hash the key one character at a time, start the polynomial remainder, then
// the combined-sum remainder after a sum state, then read, wait and check for each probe
// throughput: one item at a time; the next item is taken only once the block is back in idle
// a result shows for one cycle on done; the receiver cannot stall
// reset and a table_size write while idle or at the end of an item run a clearing sweep
// of every slot, with busy high through it; a write at other times only changes the size
`default_nettype none
module string_key_hash_table
  import skht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire skht_in_t         item,
  output logic                  done,
  output skht_out_t             result,
  input  wire logic             cfg_we,
  input  wire logic [SizeW-1:0] cfg_data
);
  skht_cmd_t cmd;
  skht_sts_t sts;

  skht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_we(cfg_we),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  skht_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .item(item), .cmd(cmd), .sts(sts), .res(result), .res_valid(done)
  );
endmodule
`default_nettype wire

// ----- rtl/core/skht_checker.sv -----
`default_nettype none
module skht_sva
  import skht_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire skht_out_t result
);
  // result comes only after work
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");
  // no result in back-to-back cycles
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
  // accepted item makes block busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");
  // misses and full carry no slot
  a_slot: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == StMiss || result.status == StFull)) |->
    (result.slot == '0 && result.found_value == '0)) else $error("bad empty result");
endmodule

bind string_key_hash_table skht_sva u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
`default_nettype wire
